>>> hdl/sps_pkg.sv
// Shared types, register indexes and the channel blend function for the sprite shader.
// No dependencies.
`default_nettype none

package sps_pkg;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_FOG_COLOR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FADE_COLOR  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FADE_FACTOR = 3'd2;
    localparam logic [IDX_W-1:0] REG_FADE_ALWAYS = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALPHA_MATCH = 3'd4;
    localparam logic [IDX_W-1:0] REG_ALPHA_PEN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_COMPOSE     = 3'd6;

    localparam logic [7:0] PEN_CLEAR = 8'hFF;
    localparam logic [7:0] CUE_HIGH  = 8'hFE;
    localparam logic [7:0] FULL_BYTE = 8'hFF;
    localparam logic [1:0] PRI_BASE  = 2'd2;
    localparam logic [1:0] PRI_HIGH  = 2'd3;

    typedef logic [7:0] chan_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // Per-pixel decisions made at entry, carried down the pipe.
    typedef struct packed {
        logic       written;
        logic       fade_en;
        logic       blend_en;
        chan_t      blend_f;
        chan_t      alpha;
        logic [1:0] pri;
    } ctl_t;

    // (c*f + o*(256-f)) >> 8, low byte kept
    function automatic chan_t mix8(input chan_t c, input chan_t o, input chan_t f);
        logic [8:0]  g;
        logic [16:0] sum;
        begin
            g   = 9'd256 - {1'b0, f};
            sum = {9'd0, c} * {9'd0, f} + {9'd0, o} * {8'd0, g};
            return sum[15:8];
        end
    endfunction

    function automatic rgb_t mix_rgb(input rgb_t c, input rgb_t o, input chan_t f);
        rgb_t res;
        begin
            res.r = mix8(c.r, o.r, f);
            res.g = mix8(c.g, o.g, f);
            res.b = mix8(c.b, o.b, f);
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/sprite_pixel_shade.sv
// Sprite pixel shader top level: config registers and the three-stage shading pipe.
// Depends on sps_pkg.
`default_nettype none

// Usage
//   Pixel channel: drive the input fields and raise start for one cycle per
//   pixel word; a word is taken at every edge where start is high and busy is
//   low. busy is always low, so a new pixel can enter every clock.
//   Result channel: done marks one cycle in which written, out_r/g/b,
//   out_alpha and priority_res hold the shaded word. The receiver takes it
//   in that cycle and cannot hold it off, so the pipe never stalls.
//   Throughput: one pixel per clock.
//   Stages: stage 1 registers the fogged colour and all per-pixel decisions,
//   stage 2 the faded colour, stage 3 the blend over the underlying colour
//   into the output registers. Each stage holds one blend per channel: an
//   8x8 and an 8x9 product summed to 17 bits, which sets the clock period.
//   Config: APB registers at byte address 4*index (fog colour, fade colour,
//   fade factor, fade always, alpha colour match, alpha pen, compose alpha).
//   Write them only while no pixel is in the pipe; the stages read them live.
//   Reset: clears the config registers and valid bits; no words are in flight after.
module sprite_pixel_shade
    import sps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // pixel command
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [7:0]        pen,
    input  wire logic [7:0]        pal_r,
    input  wire logic [7:0]        pal_g,
    input  wire logic [7:0]        pal_b,
    input  wire logic [7:0]        under_r,
    input  wire logic [7:0]        under_g,
    input  wire logic [7:0]        under_b,
    input  wire logic              under_present,
    input  wire logic [7:0]        sprite_color,
    input  wire logic [7:0]        sprite_depth_cue,
    input  wire logic              sprite_fade_enable,
    input  wire logic [7:0]        sprite_alpha,
    // result
    output logic                   done,
    output logic                   written,
    output logic      [7:0]        out_r,
    output logic      [7:0]        out_g,
    output logic      [7:0]        out_b,
    output logic      [7:0]        out_alpha,
    output logic      [1:0]        priority_res
);

    // ---------------- configuration registers ----------------
    logic [23:0] fog_color_reg;
    logic [23:0] fade_color_reg;
    logic [7:0]  fade_factor_reg;
    logic        fade_always_reg;
    logic [6:0]  alpha_match_reg;
    logic [7:0]  alpha_pen_reg;
    logic        compose_reg;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fog_color_reg   <= '0;
            fade_color_reg  <= '0;
            fade_factor_reg <= '0;
            fade_always_reg <= 1'b0;
            alpha_match_reg <= '0;
            alpha_pen_reg   <= '0;
            compose_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FOG_COLOR:   fog_color_reg   <= pwdata[23:0];
                REG_FADE_COLOR:  fade_color_reg  <= pwdata[23:0];
                REG_FADE_FACTOR: fade_factor_reg <= pwdata[7:0];
                REG_FADE_ALWAYS: fade_always_reg <= pwdata[0];
                REG_ALPHA_MATCH: alpha_match_reg <= pwdata[6:0];
                REG_ALPHA_PEN:   alpha_pen_reg   <= pwdata[7:0];
                REG_COMPOSE:     compose_reg     <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FOG_COLOR:   prdata = {8'd0, fog_color_reg};
            REG_FADE_COLOR:  prdata = {8'd0, fade_color_reg};
            REG_FADE_FACTOR: prdata = {24'd0, fade_factor_reg};
            REG_FADE_ALWAYS: prdata = {31'd0, fade_always_reg};
            REG_ALPHA_MATCH: prdata = {25'd0, alpha_match_reg};
            REG_ALPHA_PEN:   prdata = {24'd0, alpha_pen_reg};
            REG_COMPOSE:     prdata = {31'd0, compose_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- stage 1: decisions and fog ----------------
    // Nothing ever backs up, so the pipe takes a word every clock.
    assign busy = 1'b0;

    logic accept;
    logic fog_on;
    logic translucent;
    rgb_t pal_rgb;
    rgb_t fog_rgb;
    ctl_t ctl_next;
    rgb_t rgb1_next;
    rgb_t under_next;

    assign accept  = start & ~busy;
    assign pal_rgb = '{r: pal_r, g: pal_g, b: pal_b};
    assign fog_rgb = rgb_t'(fog_color_reg);
    assign fog_on  = ~sprite_color[7] & (sprite_depth_cue != 8'd0);

    assign translucent = (sprite_alpha != 8'd0)
                       & ((sprite_color[6:0] != alpha_match_reg) | (pen == alpha_pen_reg));

    always_comb
    begin
        ctl_next.written  = (pen != PEN_CLEAR);
        ctl_next.fade_en  = (fade_always_reg | sprite_fade_enable) & (fade_factor_reg != 8'd0);
        ctl_next.blend_en = translucent & ~compose_reg;
        ctl_next.blend_f  = FULL_BYTE - sprite_alpha;
        ctl_next.alpha    = (translucent & compose_reg) ? (FULL_BYTE - sprite_alpha) : FULL_BYTE;
        ctl_next.pri      = (sprite_depth_cue == CUE_HIGH) ? PRI_HIGH : PRI_BASE;
        // an absent underlying pixel blends as black
        under_next        = under_present ? rgb_t'{r: under_r, g: under_g, b: under_b}
                                          : rgb_t'('0);
        rgb1_next         = fog_on ? mix_rgb(pal_rgb, fog_rgb, FULL_BYTE - sprite_depth_cue)
                                   : pal_rgb;
    end

    logic valid1_reg;
    ctl_t ctl1_reg;
    rgb_t rgb1_reg;
    rgb_t under1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else
            valid1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg   <= ctl_next;
            rgb1_reg   <= rgb1_next;
            under1_reg <= under_next;
        end
    end

    // ---------------- stage 2: screen fade ----------------
    rgb_t rgb2_next;

    assign rgb2_next = ctl1_reg.fade_en
                     ? mix_rgb(rgb1_reg, rgb_t'(fade_color_reg), FULL_BYTE - fade_factor_reg)
                     : rgb1_reg;

    logic valid2_reg;
    ctl_t ctl2_reg;
    rgb_t rgb2_reg;
    rgb_t under2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else
            valid2_reg <= valid1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (valid1_reg)
        begin
            ctl2_reg   <= ctl1_reg;
            rgb2_reg   <= rgb2_next;
            under2_reg <= under1_reg;
        end
    end

    // ---------------- stage 3: blend and output registers ----------------
    rgb_t rgb3_next;

    assign rgb3_next = ctl2_reg.blend_en ? mix_rgb(rgb2_reg, under2_reg, ctl2_reg.blend_f)
                                         : rgb2_reg;

    logic       done_reg;
    logic       written_reg;
    rgb_t       out_rgb_reg;
    logic [7:0] out_alpha_reg;
    logic [1:0] pri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid2_reg;
    end

    // a transparent pen drives every field to zero
    always_ff @(posedge clk)
    begin
        if (valid2_reg)
        begin
            written_reg   <= ctl2_reg.written;
            out_rgb_reg   <= ctl2_reg.written ? rgb3_next : '0;
            out_alpha_reg <= ctl2_reg.written ? ctl2_reg.alpha : 8'd0;
            pri_reg       <= ctl2_reg.written ? ctl2_reg.pri : 2'd0;
        end
    end

    assign done         = done_reg;
    assign written      = written_reg;
    assign out_r        = out_rgb_reg.r;
    assign out_g        = out_rgb_reg.g;
    assign out_b        = out_rgb_reg.b;
    assign out_alpha    = out_alpha_reg;
    assign priority_res = pri_reg;

endmodule

`default_nettype wire

>>> hdl/sps_checker.sv
// Port-level checks for sprite_pixel_shade, bound to the top level.
// Depends on sps_pkg.
`default_nettype none

module sps_checker
    import sps_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       written,
    input wire logic [7:0] out_r,
    input wire logic [7:0] out_g,
    input wire logic [7:0] out_b,
    input wire logic [7:0] out_alpha,
    input wire logic [1:0] priority_res
);

    // every accepted word comes out with done once it has passed the pipe registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted word did not complete after three cycles");

    // no result without a matching accepted word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result strobe without an accepted word");

    // a transparent pen gives an all-zero word
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !written) |-> (out_r == 8'd0 && out_g == 8'd0 && out_b == 8'd0
                                && out_alpha == 8'd0 && priority_res == 2'd0))
        else $error("transparent pen produced nonzero fields");

    // a written pixel always carries priority 2 or 3
    a_pri: assert property (@(posedge clk) disable iff (!rst_n)
        (done && written) |-> (priority_res == PRI_BASE || priority_res == PRI_HIGH))
        else $error("written pixel with bad priority");

endmodule

bind sprite_pixel_shade sps_checker u_sps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .written      (written),
    .out_r        (out_r),
    .out_g        (out_g),
    .out_b        (out_b),
    .out_alpha    (out_alpha),
    .priority_res (priority_res)
);

`default_nettype wire

>>> test/sprite_pixel_shade_tb.sv
// Self-checking testbench for sprite_pixel_shade: a directed table of pixels, then random
// pixels under several register settings, each result checked against a table entry or a local predictor.
// Depends on sps_pkg and sprite_pixel_shade.
`timescale 1ns / 1ps

module sprite_pixel_shade_tb
    import sps_pkg::*;
;

    // Depth of the shading pipe: edges from acceptance to the done cycle.
    localparam int PIPE_DEPTH  = 3;
    // Generous ceiling on the run, in clock cycles.
    localparam int CYCLE_LIMIT = 100000;
    localparam int DIR_N       = 18;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 186;
    // No idle cycles on the pixel side from this many words sent until BURST_TO.
    localparam int BURST_FROM  = 500;
    localparam int BURST_TO    = 800;

    // One pixel word, in port order.
    typedef struct packed {
        chan_t      pen;
        chan_t      pal_r;
        chan_t      pal_g;
        chan_t      pal_b;
        chan_t      under_r;
        chan_t      under_g;
        chan_t      under_b;
        logic       under_present;
        chan_t      color;
        chan_t      cue;
        logic       fade_en;
        chan_t      alpha;
    } pixel_t;

    // One shaded word as it leaves the block.
    typedef struct packed {
        logic       written;
        chan_t      r;
        chan_t      g;
        chan_t      b;
        chan_t      a;
        logic [1:0] pri;
    } shade_t;

    // Local copy of the register file, updated on every write.
    typedef struct packed {
        rgb_t       fog;
        rgb_t       fade;
        chan_t      fade_factor;
        logic       fade_all;
        logic [6:0] bank;
        chan_t      apen;
        logic       compose;
    } shade_regs_t;

    // Directed row: a pixel and, where it is obvious, the shaded word it must give.
    typedef struct {
        pixel_t     px;
        bit         typed;
        shade_t     want;
    } dir_row_t;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start   = 1'b0;
    logic              busy;
    pixel_t            px_drv  = '0;
    logic              done;
    logic              written;
    logic [7:0]        out_r;
    logic [7:0]        out_g;
    logic [7:0]        out_b;
    logic [7:0]        out_alpha;
    logic [1:0]        priority_res;

    shade_regs_t       regs = '0;
    shade_t            shade_q[$];
    shade_t            head;
    dir_row_t          dir_tab[DIR_N];
    int                errors = 0;
    int                sent   = 0;
    int                cycles = 0;

    sprite_pixel_shade DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .pen                (px_drv.pen),
        .pal_r              (px_drv.pal_r),
        .pal_g              (px_drv.pal_g),
        .pal_b              (px_drv.pal_b),
        .under_r            (px_drv.under_r),
        .under_g            (px_drv.under_g),
        .under_b            (px_drv.under_b),
        .under_present      (px_drv.under_present),
        .sprite_color       (px_drv.color),
        .sprite_depth_cue   (px_drv.cue),
        .sprite_fade_enable (px_drv.fade_en),
        .sprite_alpha       (px_drv.alpha),
        .done               (done),
        .written            (written),
        .out_r              (out_r),
        .out_g              (out_g),
        .out_b              (out_b),
        .out_alpha          (out_alpha),
        .priority_res       (priority_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Linear blend of one channel: weight f on c, the rest on o, keep the top byte.
    function automatic chan_t lerp_chan(input chan_t c, input chan_t o, input chan_t f);
        int unsigned acc;
        begin
            acc = int'(c) * int'(f) + int'(o) * (256 - int'(f));
            return chan_t'(acc >> 8);
        end
    endfunction

    function automatic rgb_t lerp_rgb(input rgb_t c, input rgb_t o, input chan_t f);
        rgb_t res;
        begin
            res.r = lerp_chan(c.r, o.r, f);
            res.g = lerp_chan(c.g, o.g, f);
            res.b = lerp_chan(c.b, o.b, f);
            return res;
        end
    endfunction

    // Shade one pixel against the current register copy.
    function automatic shade_t shade_pixel(input pixel_t px);
        shade_t res;
        rgb_t   col;
        rgb_t   under;
        logic   see_through;
        begin
            res = '0;
            // Transparent pen: nothing is written and every field stays zero.
            if (px.pen == PEN_CLEAR)
                return res;
            col = '{px.pal_r, px.pal_g, px.pal_b};
            // Fog only for sprites that leave color bit 7 clear and carry a depth cue.
            if (!px.color[7] && px.cue != 8'h00)
                col = lerp_rgb(col, regs.fog, FULL_BYTE - px.cue);
            if ((regs.fade_all || px.fade_en) && regs.fade_factor != 8'h00)
                col = lerp_rgb(col, regs.fade, FULL_BYTE - regs.fade_factor);
            res.a = FULL_BYTE;
            // In the matching bank only the alpha pen is see-through.
            see_through = (px.alpha != 8'h00) &&
                          (px.color[6:0] != regs.bank || px.pen == regs.apen);
            if (see_through)
            begin
                if (regs.compose)
                    res.a = FULL_BYTE - px.alpha;
                else
                begin
                    under = px.under_present ? rgb_t'({px.under_r, px.under_g, px.under_b})
                                             : rgb_t'('0);
                    col = lerp_rgb(col, under, FULL_BYTE - px.alpha);
                end
            end
            res.written = 1'b1;
            res.r       = col.r;
            res.g       = col.g;
            res.b       = col.b;
            res.pri     = (px.cue == CUE_HIGH) ? PRI_HIGH : PRI_BASE;
            return res;
        end
    endfunction

    // Random pixel, steered toward the pens, banks and cues that change the outcome.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        logic [95:0] raw;
        begin
            raw = {$urandom, $urandom, $urandom};
            px  = raw[$bits(pixel_t)-1:0];
            case ($urandom_range(0, 9))
                0:       px.pen = PEN_CLEAR;
                1, 2:    px.pen = regs.apen;
                3:       px.pen = 8'h00;
                default: px.pen = chan_t'($urandom);
            endcase
            if ($urandom_range(0, 9) < 3)
                px.color[6:0] = regs.bank;
            case ($urandom_range(0, 9))
                0:       px.cue = 8'h00;
                1:       px.cue = CUE_HIGH;
                2:       px.cue = FULL_BYTE;
                default: px.cue = chan_t'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0, 1:    px.alpha = 8'h00;
                2:       px.alpha = FULL_BYTE;
                default: px.alpha = chan_t'($urandom);
            endcase
            return px;
        end
    endfunction

    // Offer one pixel word, hold it until taken, then log what it must produce.
    task automatic drive_pixel(input pixel_t px, input bit use_want, input shade_t want);
        begin
            // Outside the burst window, idle the pixel side so that about 36 percent of cycles go unused.
            while ((sent < BURST_FROM || sent >= BURST_TO) && $urandom_range(0, 99) < 36)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start  <= 1'b1;
            px_drv <= px;
            do
                @(posedge clk);
            while (busy);
            shade_q.push_back(use_want ? want : shade_pixel(px));
            sent++;
        end
    endtask

    // Drop start and wait for the pipe to empty.
    task automatic drain();
        begin
            start <= 1'b0;
            while (shade_q.size() != 0)
                @(posedge clk);
        end
    endtask

    // APB write then read-back of one register. psel stays high; the caller drops it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] kept;
        begin
            kept = '0;
            case (idx)
                REG_FOG_COLOR:   begin regs.fog         = val[23:0]; kept[23:0] = val[23:0]; end
                REG_FADE_COLOR:  begin regs.fade        = val[23:0]; kept[23:0] = val[23:0]; end
                REG_FADE_FACTOR: begin regs.fade_factor = val[7:0];  kept[7:0]  = val[7:0];  end
                REG_FADE_ALWAYS: begin regs.fade_all    = val[0];    kept[0]    = val[0];    end
                REG_ALPHA_MATCH: begin regs.bank        = val[6:0];  kept[6:0]  = val[6:0];  end
                REG_ALPHA_PEN:   begin regs.apen        = val[7:0];  kept[7:0]  = val[7:0];  end
                REG_COMPOSE:     begin regs.compose     = val[0];    kept[0]    = val[0];    end
                default:         ;
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            // Read back: go straight from the write access into a read setup.
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== kept)
            begin
                $error("prdata[%0d]: expected %0h, got %0h", idx, kept, prdata);
                errors++;
            end
        end
    endtask

    // Write every register once, then release the bus.
    task automatic set_regs(input logic [31:0] fog, input logic [31:0] fade,
                            input logic [31:0] factor, input logic [31:0] fade_all,
                            input logic [31:0] bank, input logic [31:0] apen,
                            input logic [31:0] compose);
        begin
            write_reg(REG_FOG_COLOR,   fog);
            write_reg(REG_FADE_COLOR,  fade);
            write_reg(REG_FADE_FACTOR, factor);
            write_reg(REG_FADE_ALWAYS, fade_all);
            write_reg(REG_ALPHA_MATCH, bank);
            write_reg(REG_ALPHA_PEN,   apen);
            write_reg(REG_COMPOSE,     compose);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Walk the directed table; typed words only hold under the reset settings.
    task automatic run_table(input bit typed_ok);
        begin
            for (int i = 0; i < DIR_N; i++)
                drive_pixel(dir_tab[i].px, typed_ok && dir_tab[i].typed, dir_tab[i].want);
        end
    endtask

    // Result side: the block cannot be held off, so take every done cycle as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (shade_q.size() == 0)
            begin
                $error("shaded word with no pixel outstanding");
                errors++;
            end
            else
            begin
                head = shade_q.pop_front();
                if (written !== head.written)
                begin
                    $error("written: expected %0h, got %0h", head.written, written);
                    errors++;
                end
                if (out_r !== head.r)
                begin
                    $error("out_r: expected %0h, got %0h", head.r, out_r);
                    errors++;
                end
                if (out_g !== head.g)
                begin
                    $error("out_g: expected %0h, got %0h", head.g, out_g);
                    errors++;
                end
                if (out_b !== head.b)
                begin
                    $error("out_b: expected %0h, got %0h", head.b, out_b);
                    errors++;
                end
                if (out_alpha !== head.a)
                begin
                    $error("out_alpha: expected %0h, got %0h", head.a, out_alpha);
                    errors++;
                end
                if (priority_res !== head.pri)
                begin
                    $error("priority_res: expected %0h, got %0h", head.pri, priority_res);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        // Fields: pen, pal r g b, under r g b, under_present, color, cue, fade_en, alpha.
        // Transparent pen, most fields at max, then all at zero: an all-zero word either way.
        dir_tab[0]  = '{'{PEN_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                          8'h00, 8'h80, 1'b1, 8'hFF}, 1'b1, '0};
        dir_tab[1]  = '{'{PEN_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h00, 8'h00, 1'b0, 8'h00}, 1'b1, '0};
        // Opaque, fog off by color bit 7: palette passes through.
        dir_tab[2]  = '{'{8'h00, 8'h12, 8'h34, 8'h56, 8'hAA, 8'hBB, 8'hCC, 1'b1,
                          8'h80, 8'h00, 1'b0, 8'h00}, 1'b1,
                        '{1'b1, 8'h12, 8'h34, 8'h56, FULL_BYTE, PRI_BASE}};
        // Cue of 0xFE raises priority even with fog off.
        dir_tab[3]  = '{'{8'hFE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'hFF, CUE_HIGH, 1'b0, 8'h00}, 1'b1,
                        '{1'b1, 8'hFF, 8'h00, 8'hFF, FULL_BYTE, PRI_HIGH}};
        // Cue of 0xFF is not the high-priority code.
        dir_tab[4]  = '{'{8'h10, 8'h01, 8'h80, 8'hFE, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h85, 8'hFF, 1'b0, 8'h00}, 1'b1,
                        '{1'b1, 8'h01, 8'h80, 8'hFE, FULL_BYTE, PRI_BASE}};
        // Fog at mid, full and minimal strength, and fog with the high-priority cue.
        dir_tab[5]  = '{'{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h01, 8'h80, 1'b0, 8'h00}, 1'b0, '0};
        dir_tab[6]  = '{'{8'h21, 8'hC0, 8'h40, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h00, 8'hFF, 1'b0, 8'h00}, 1'b0, '0};
        dir_tab[7]  = '{'{8'h22, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h02, 8'h01, 1'b0, 8'h00}, 1'b0, '0};
        dir_tab[8]  = '{'{8'h23, 8'h90, 8'hA0, 8'hB0, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h03, CUE_HIGH, 1'b0, 8'h00}, 1'b0, '0};
        // Matching bank, pen not the alpha pen: stays opaque.
        dir_tab[9]  = '{'{8'h05, 8'h11, 8'h22, 8'h33, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                          8'h80, 8'h00, 1'b0, 8'h80}, 1'b1,
                        '{1'b1, 8'h11, 8'h22, 8'h33, FULL_BYTE, PRI_BASE}};
        // Matching bank on the alpha pen, then another bank: both blend.
        dir_tab[10] = '{'{8'h00, 8'h11, 8'h22, 8'h33, 8'hF0, 8'h0F, 8'h80, 1'b1,
                          8'h80, 8'h00, 1'b0, 8'h80}, 1'b0, '0};
        dir_tab[11] = '{'{8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0,
                          8'h81, 8'h00, 1'b0, 8'hFF}, 1'b0, '0};
        dir_tab[12] = '{'{8'h41, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                          8'h81, 8'h00, 1'b0, 8'hFF}, 1'b0, '0};
        dir_tab[13] = '{'{8'h42, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h7F, 1'b1,
                          8'h7E, 8'h00, 1'b1, 8'h01}, 1'b0, '0};
        // Sprite fade enabled while the fade factor is zero: no effect.
        dir_tab[14] = '{'{8'h50, 8'h9A, 8'hBC, 8'hDE, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h80, 8'h33, 1'b1, 8'h00}, 1'b1,
                        '{1'b1, 8'h9A, 8'hBC, 8'hDE, FULL_BYTE, PRI_BASE}};
        // Every field at its top value, the pen just short of transparent.
        dir_tab[15] = '{'{8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                          8'hFF, 8'hFF, 1'b1, 8'hFF}, 1'b0, '0};
        // Every field zero: opaque black.
        dir_tab[16] = '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                          8'h00, 8'h00, 1'b0, 8'h00}, 1'b1,
                        '{1'b1, 8'h00, 8'h00, 8'h00, FULL_BYTE, PRI_BASE}};
        dir_tab[17] = '{'{8'h7F, 8'h55, 8'hAA, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b1,
                          8'h2A, 8'h77, 1'b1, 8'h99}, 1'b0, '0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass under the reset settings, then again with fade, fog and compose on.
        run_table(1'b1);
        drain();
        set_regs(32'h00FF_8040, 32'h0000_00FF, 32'h40, 32'h0, 32'h0, 32'h5, 32'h1);
        run_table(1'b0);
        drain();

        // Random phases: extremes first, then near-zero settings, then random ones.
        // Raw 32-bit writes also check that unused register bits are dropped.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_regs('1, '1, '1, '1, '1, '1, '1);
                1:       set_regs('0, '0, 32'h1, '0, '0, '0, '0);
                default: set_regs($urandom, $urandom,
                                  ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                                  $urandom, $urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_pixel(random_pixel(), 1'b0, '0);
            drain();
        end

        // Catch any stray word the pipe might still push out.
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
